// ----- hw/rtl/bpa_pkg.sv -----
// bpa_pkg: shared constants and types for the bitmap page allocator
// depends on nothing; imported by the allocator top level and its checker
`default_nettype none

package bpa_pkg;

    // managed region geometry
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int MAP_BYTES  = MAX_PAGES / 8;
    localparam int BYTE_W     = $clog2(MAP_BYTES);
    localparam int PAGE_W     = BYTE_W + 3;
    localparam int LIMIT_W    = BYTE_W + 1;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int PAGE_IDX_W = 15;
    localparam int PAGE_OUT_W = 20;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = CFG_IDX_W'(1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC     = 2'd0,
        ACT_MARK      = 2'd1,
        ACT_PAGE2ADDR = 2'd2,
        ACT_ADDR2PAGE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_START,
        ST_ALLOC_CHECK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_CALC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bitmap_page_allocator_top.sv -----
// bitmap_page_allocator_top: page frame allocator with used-page bitmap and next-fit hint
// depends on bpa_pkg and bpa_ram
//
//  channel   dir  handshake          payload
//  request   in   in_valid/in_stall  action, page_index, address_in
//  result    out  out_valid/out_stall address_out, page_out, fail
//  config    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a request is taken only when the sequencer is idle, then in_stall stays high until done
// convert actions pass through the calc and done states; mark reads the bitmap byte and
// writes it back with the page bit set; allocate reads the hint byte, then scans the bitmap
// byte by byte up to the search end; the single bitmap ram read port sets the scan pace
// after reset a clearing pass writes zero to all 4096 bitmap bytes, one per cycle,
// with in_stall high; config writes are taken at any time
// the result sits in an output register, so a stalled result does not block the next request
`default_nettype none

module bitmap_page_allocator_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [bpa_pkg::ACTION_W-1:0]     action,
    input  wire logic [bpa_pkg::PAGE_IDX_W-1:0]   page_index,
    input  wire logic [bpa_pkg::ADDR_W-1:0]       address_in,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [bpa_pkg::ADDR_W-1:0]       address_out,
    output logic      [bpa_pkg::PAGE_OUT_W-1:0]   page_out,
    output logic                                  fail,
    // configuration channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpa_pkg::ADDR_W-1:0]       cfg_data
);

    import bpa_pkg::*;

    // lowest set bit of a byte
    function automatic logic [2:0] low_bit(input logic [7:0] v);
        logic [2:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    // sequencer state
    state_t state_reg, state_next;

    // clearing pass counter
    logic [BYTE_W-1:0] clr_cnt_reg, clr_cnt_next;

    // latched request
    action_t               act_reg, act_next;
    logic [PAGE_OUT_W-1:0] work_page_reg, work_page_next;
    logic [ADDR_W-1:0]     addr_in_reg, addr_in_next;

    // scan position and allocator hint
    logic [BYTE_W-1:0] byte_ptr_reg, byte_ptr_next;
    logic [2:0]        bit_start_reg, bit_start_next;
    logic [PAGE_W-1:0] hint_reg, hint_next;

    // configuration
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [COUNT_W-1:0] pages_reg, pages_next;

    // pending result
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [PAGE_OUT_W-1:0] res_page_reg, res_page_next;
    logic                  res_fail_reg, res_fail_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [PAGE_OUT_W-1:0] out_page_reg, out_page_next;
    logic                  out_fail_reg, out_fail_next;

    // bitmap ram
    logic              ram_we;
    logic [BYTE_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    bpa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake terms
    logic in_take;
    logic out_load;

    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    // search end in bytes: min(page_count, MAX_PAGES) / 8
    logic [31:0]        limit_full;
    logic [LIMIT_W-1:0] limit_bytes;

    assign limit_full  = 32'(pages_reg) >> 3;
    assign limit_bytes = (limit_full > 32'(MAP_BYTES)) ? LIMIT_W'(MAP_BYTES)
                                                       : LIMIT_W'(limit_full);

    // hint byte and bit
    logic [BYTE_W-1:0] hint_byte;
    logic              hint_past_end;

    assign hint_byte     = hint_reg[PAGE_W-1:3];
    assign hint_past_end = ({1'b0, hint_byte} >= limit_bytes);

    // byte scan
    logic [7:0]         free_mask;
    logic               scan_hit;
    logic [2:0]         hit_bit;
    logic [LIMIT_W-1:0] byte_inc;

    assign free_mask = ~ram_rdata & (8'hFF << bit_start_reg);
    assign scan_hit  = |free_mask;
    assign hit_bit   = low_bit(free_mask);
    assign byte_inc  = {1'b0, byte_ptr_reg} + LIMIT_W'(1);

    // mark target
    logic [BYTE_W-1:0] mark_byte;
    logic              mark_in_map;

    assign mark_byte   = BYTE_W'(work_page_reg >> 3);
    assign mark_in_map = ((32'(work_page_reg) >> 3) < 32'(MAP_BYTES));

    // shared adder: base + page*4096, or address - base
    logic              sub_mode;
    logic [ADDR_W-1:0] add_a;
    logic [ADDR_W-1:0] add_b;
    logic [ADDR_W-1:0] add_sum;

    assign sub_mode = (act_reg == ACT_ADDR2PAGE);
    assign add_a    = sub_mode ? ~base_reg : base_reg;
    assign add_b    = sub_mode ? addr_in_reg : (ADDR_W'(work_page_reg) << PAGE_SHIFT);
    assign add_sum  = add_a + add_b + ADDR_W'(sub_mode);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BYTE_W'(MAP_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (action_t'(action))
                        ACT_ALLOC:     state_next = ST_ALLOC_START;
                        ACT_MARK:      state_next = ST_MARK_RD;
                        default:       state_next = ST_CALC;
                    endcase
                end
            end
            ST_ALLOC_START:
            begin
                state_next = hint_past_end ? ST_DONE : ST_ALLOC_CHECK;
            end
            ST_ALLOC_CHECK:
            begin
                if (scan_hit)
                begin
                    state_next = ST_CALC;
                end
                else if (byte_inc >= limit_bytes)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK_RD:     state_next = ST_MARK_WR;
            ST_MARK_WR:     state_next = ST_CALC;
            ST_CALC:        state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: ram controls and datapath updates
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        act_next       = act_reg;
        work_page_next = work_page_reg;
        addr_in_next   = addr_in_reg;
        byte_ptr_next  = byte_ptr_reg;
        bit_start_next = bit_start_reg;
        hint_next      = hint_reg;
        res_addr_next  = res_addr_reg;
        res_page_next  = res_page_reg;
        res_fail_next  = res_fail_reg;
        ram_we         = 1'b0;
        ram_waddr      = byte_ptr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = byte_ptr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + BYTE_W'(1);
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    act_next       = action_t'(action);
                    work_page_next = PAGE_OUT_W'(page_index);
                    addr_in_next   = address_in;
                end
            end
            ST_ALLOC_START:
            begin
                // read the hint byte; the scan starts at the hint bit
                ram_re         = 1'b1;
                ram_raddr      = hint_byte;
                byte_ptr_next  = hint_byte;
                bit_start_next = hint_reg[2:0];
                if (hint_past_end)
                begin
                    res_addr_next = '1;
                    res_page_next = '0;
                    res_fail_next = 1'b1;
                end
            end
            ST_ALLOC_CHECK:
            begin
                if (scan_hit)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = byte_ptr_reg;
                    ram_wdata      = ram_rdata | (8'h01 << hit_bit);
                    hint_next      = {byte_ptr_reg, hit_bit};
                    work_page_next = PAGE_OUT_W'({byte_ptr_reg, hit_bit});
                end
                else if (byte_inc >= limit_bytes)
                begin
                    res_addr_next = '1;
                    res_page_next = '0;
                    res_fail_next = 1'b1;
                end
                else
                begin
                    // later bytes scan from bit zero
                    ram_re         = 1'b1;
                    ram_raddr      = byte_inc[BYTE_W-1:0];
                    byte_ptr_next  = byte_inc[BYTE_W-1:0];
                    bit_start_next = '0;
                end
            end
            ST_MARK_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = mark_byte;
            end
            ST_MARK_WR:
            begin
                ram_we    = mark_in_map;
                ram_waddr = mark_byte;
                ram_wdata = ram_rdata | (8'h01 << work_page_reg[2:0]);
            end
            ST_CALC:
            begin
                res_fail_next = 1'b0;
                if (sub_mode)
                begin
                    res_addr_next = '0;
                    res_page_next = PAGE_OUT_W'(add_sum >> PAGE_SHIFT);
                end
                else
                begin
                    res_addr_next = add_sum;
                    res_page_next = work_page_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        base_next  = base_reg;
        pages_next = pages_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS: base_next  = cfg_data;
                CFG_PAGE_COUNT:   pages_next = COUNT_W'(cfg_data);
                default:          base_next  = base_reg;
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_page_next  = out_page_reg;
        out_fail_next  = out_fail_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = res_addr_reg;
            out_page_next  = res_page_reg;
            out_fail_next  = res_fail_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign address_out = out_addr_reg;
    assign page_out    = out_page_reg;
    assign fail        = out_fail_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hint_reg      <= '0;
            base_reg      <= '0;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hint_reg      <= hint_next;
            base_reg      <= base_next;
            pages_reg     <= pages_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        work_page_reg <= work_page_next;
        addr_in_reg   <= addr_in_next;
        byte_ptr_reg  <= byte_ptr_next;
        bit_start_reg <= bit_start_next;
        res_addr_reg  <= res_addr_next;
        res_page_reg  <= res_page_next;
        res_fail_reg  <= res_fail_next;
        out_addr_reg  <= out_addr_next;
        out_page_reg  <= out_page_next;
        out_fail_reg  <= out_fail_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpa_ram.sv -----
// bpa_ram: generic simple dual-port ram, one write port, one registered read port
// depends on nothing
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpa_checker.sv -----
// bpa_checker: port-level assertions for the bitmap page allocator, bound to the top level
// depends on bpa_pkg and bitmap_page_allocator_top
`default_nettype none

module bpa_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [bpa_pkg::ADDR_W-1:0]       address_out,
    input wire logic [bpa_pkg::PAGE_OUT_W-1:0]   page_out,
    input wire logic                             fail
);

    import bpa_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(address_out)
            && $stable(page_out) && $stable(fail))
        else $error("result changed while stalled");

    // one request at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one in flight");

    // a failed allocation returns all ones and page zero
    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fail |-> (address_out == '1) && (page_out == '0))
        else $error("failed allocation with bad result value");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (.*);

`default_nettype wire
